>>> hw/rtl/sp36_pkg.sv
package sp36_pkg;

   // Payload layout
   localparam int PREFIX_LEN   = 7;
   localparam int SYMBOL_COUNT = 9;
   localparam int ID_LEN       = 4;
   localparam int PAYLOAD_LEN  = PREFIX_LEN + SYMBOL_COUNT + ID_LEN;
   localparam int IDX_W        = $clog2(PAYLOAD_LEN);

   // Base-36 conversion: the word is shifted into the cell row a chunk at a time
   localparam int RADIX    = 36;
   localparam int DIGIT_W  = 6;
   localparam int CHUNK_W  = 3;
   localparam int VAL_W    = DIGIT_W + CHUNK_W;
   localparam int WORD_W   = 48;
   localparam int STEPS    = WORD_W / CHUNK_W;
   localparam int STEP_W   = $clog2(STEPS);
   localparam int CODE_W   = 27;
   localparam int SEL_W    = $clog2(SYMBOL_COUNT);

   // Items accepted but not yet fully delivered
   localparam int MAX_INFLIGHT = 3;
   localparam int INFLIGHT_W   = $clog2(MAX_INFLIGHT + 1);

   // Register map
   localparam int CSR_INDEX_W = 8;
   localparam logic [CSR_INDEX_W-1:0] CSR_CATEGORY = 8'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_BLE      = 8'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_IP       = 8'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_SETUP_ID = 8'd3;

   localparam logic [7:0] ASCII_ZERO = 8'h30;
   localparam logic [7:0] ASCII_A    = 8'h41;

   localparam logic [7:0] PREFIX_TEXT [PREFIX_LEN] = '{
      8'h58, 8'h2D, 8'h48, 8'h4D, 8'h3A, 8'h2F, 8'h2F
   };

   localparam logic [CODE_W-1:0] DIGIT_WEIGHT [8] = '{
      27'd10000000, 27'd1000000, 27'd100000, 27'd10000,
      27'd1000, 27'd100, 27'd10, 27'd1
   };

   typedef struct packed {
      logic [3:0] digit_0;
      logic [3:0] digit_1;
      logic [3:0] digit_2;
      logic [3:0] digit_3;
      logic [3:0] digit_4;
      logic [3:0] digit_5;
      logic [3:0] digit_6;
      logic [3:0] digit_7;
      logic       paired;
      logic       has_code;
   } req_type;

   typedef struct packed {
      logic [7:0] symbol;
      logic       last;
   } rsp_type;

   typedef struct packed {
      logic [7:0]       category;
      logic             ble_supported;
      logic             ip_supported;
      logic [3:0][7:0]  setup_id_chars;
   } cfg_type;

   // What one cell hands to the next
   typedef struct packed {
      logic               valid;
      logic               first;
      logic               last;
      logic               tag;
      logic [CHUNK_W-1:0] chunk;
   } step_type;

   typedef struct packed {
      logic [SYMBOL_COUNT-1:0][DIGIT_W-1:0] digits;
      logic                                 use_code;
   } frame_type;

   typedef struct packed {
      logic [CHUNK_W-1:0] quot;
      logic [DIGIT_W-1:0] rem;
   } div_type;

   function automatic div_type div_radix(input logic [VAL_W-1:0] value);
      div_type          res;
      logic [VAL_W-1:0] base;
      res.quot = '0;
      for (int k = 1; k < (1 << CHUNK_W); k++) begin
         if (value >= VAL_W'(RADIX * k)) begin
            res.quot = CHUNK_W'(k);
         end
      end
      base = VAL_W'(RADIX) * VAL_W'(res.quot);
      res.rem = DIGIT_W'(value - base);
      return res;
   endfunction

   function automatic logic [7:0] symbol_of(input logic [DIGIT_W-1:0] v);
      logic [7:0] res;
      if (v < DIGIT_W'(10)) begin
         res = ASCII_ZERO + 8'(v);
      end else begin
         res = ASCII_A + 8'(v - DIGIT_W'(10));
      end
      return res;
   endfunction

   function automatic logic [3:0] clamp_digit(input logic [3:0] d);
      return (d > 4'd9) ? 4'd9 : d;
   endfunction

endpackage

>>> hw/rtl/sp36_cell.sv
module sp36_cell
   import sp36_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  step_type           chain_in,
   output step_type           chain_out,
   output logic [DIGIT_W-1:0] result
);

   logic [DIGIT_W-1:0] digit_ff, digit_in;
   logic [DIGIT_W-1:0] result_ff, result_in;
   step_type           step_ff, step_in;
   logic [VAL_W-1:0]   acc;
   div_type            dv;

   always_comb begin
      // digit * 8 + chunk; a new item starts from zero
      acc = chain_in.first ? VAL_W'(chain_in.chunk) : {digit_ff, chain_in.chunk};
      dv  = div_radix(acc);
      digit_in  = chain_in.valid ? dv.rem : digit_ff;
      result_in = (chain_in.valid && chain_in.last) ? dv.rem : result_ff;
      step_in       = chain_in;
      step_in.chunk = dv.quot;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= '0;
      end else begin
         step_ff <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      digit_ff  <= digit_in;
      result_ff <= result_in;
   end

   assign chain_out = step_ff;
   assign result    = result_ff;

endmodule

>>> hw/rtl/sp36_front.sv
module sp36_front
   import sp36_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  req_type  req_data,
   input  logic     req_take,
   input  cfg_type  cfg,
   output logic     slot_free,
   output step_type chain_out
);

   logic                    b_valid_ff, b_valid_in;
   logic [3:0][CODE_W-1:0]  pair_ff, pair_in;
   logic                    paired_ff, paired_in;
   logic                    use_ff, use_in;

   logic [WORD_W-1:0]       feed_ff, feed_in;
   logic [STEP_W-1:0]       cnt_ff, cnt_in;
   logic                    active_ff, active_in;
   logic                    tag_ff, tag_in;

   logic [3:0][7:0]         digits;
   logic                    use_code;
   logic                    last_step;
   logic                    feed_load;
   logic [CODE_W-1:0]       code;

   assign digits = {req_data.digit_0, req_data.digit_1, req_data.digit_2, req_data.digit_3,
                    req_data.digit_4, req_data.digit_5, req_data.digit_6, req_data.digit_7};
   assign use_code  = req_data.has_code && !req_data.paired;
   assign last_step = (cnt_ff == STEP_W'(STEPS - 1));
   assign feed_load = b_valid_ff && (!active_ff || last_step);
   assign slot_free = !b_valid_ff || feed_load;
   assign code      = (pair_ff[0] + pair_ff[1]) + (pair_ff[2] + pair_ff[3]);

   // stage one: clamp digits and form pair sums
   always_comb begin
      b_valid_in = b_valid_ff;
      pair_in    = pair_ff;
      paired_in  = paired_ff;
      use_in     = use_ff;
      if (feed_load) begin
         b_valid_in = 1'b0;
      end
      if (req_take) begin
         b_valid_in = 1'b1;
         paired_in  = req_data.paired;
         use_in     = use_code;
         for (int p = 0; p < 4; p++) begin
            if (use_code) begin
               pair_in[p] =
                  CODE_W'(clamp_digit(digits[3 - p][7:4])) * DIGIT_WEIGHT[2 * p] +
                  CODE_W'(clamp_digit(digits[3 - p][3:0])) * DIGIT_WEIGHT[2 * p + 1];
            end else begin
               pair_in[p] = '0;
            end
         end
      end
   end

   // stage two: feed the packed word into the cell row, one chunk a cycle
   always_comb begin
      feed_in   = feed_ff;
      cnt_in    = cnt_ff;
      active_in = active_ff;
      tag_in    = tag_ff;
      if (feed_load) begin
         feed_in   = {9'd0, cfg.category, 1'b0, cfg.ble_supported, cfg.ip_supported,
                      paired_ff, code};
         cnt_in    = '0;
         active_in = 1'b1;
         tag_in    = use_ff;
      end else if (active_ff) begin
         feed_in = feed_ff << CHUNK_W;
         cnt_in  = cnt_ff + STEP_W'(1);
         if (last_step) begin
            active_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
         active_ff  <= 1'b0;
         cnt_ff     <= '0;
      end else begin
         b_valid_ff <= b_valid_in;
         active_ff  <= active_in;
         cnt_ff     <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      pair_ff   <= pair_in;
      paired_ff <= paired_in;
      use_ff    <= use_in;
      feed_ff   <= feed_in;
      tag_ff    <= tag_in;
   end

   always_comb begin
      chain_out.valid = active_ff;
      chain_out.first = (cnt_ff == '0);
      chain_out.last  = last_step;
      chain_out.tag   = tag_ff;
      chain_out.chunk = feed_ff[WORD_W-1 -: CHUNK_W];
   end

endmodule

>>> hw/rtl/sp36_ser.sv
module sp36_ser
   import sp36_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      frame_valid,
   input  frame_type frame_data,
   input  cfg_type   cfg,
   output logic      rsp_valid,
   input  logic      rsp_ready,
   output rsp_type   rsp_data
);

   localparam int QDepth = 2;
   localparam int QCntW  = $clog2(QDepth + 1);
   localparam int QPosW  = $clog2(QDepth);

   frame_type              q_ff [QDepth];
   logic [QCntW-1:0]       q_cnt_ff, q_cnt_in;
   logic [QPosW-1:0]       wr_pos;

   frame_type              cur_ff, cur_in;
   logic                   cur_valid_ff, cur_valid_in;
   logic [IDX_W-1:0]       idx_ff, idx_in;

   logic                   rsp_valid_ff, rsp_valid_in;
   rsp_type                rsp_ff, rsp_in;

   logic                   out_free, emit, cur_done, load;
   logic [IDX_W-1:0]       sym_pos, id_pos;
   logic [SEL_W-1:0]       sym_sel;
   logic [1:0]             id_sel;
   logic [7:0]             ch;

   assign out_free = !rsp_valid_ff || rsp_ready;
   assign emit     = cur_valid_ff && out_free;
   assign cur_done = emit && (idx_ff == IDX_W'(PAYLOAD_LEN - 1));
   assign load     = (q_cnt_ff != '0) && (!cur_valid_ff || cur_done);
   assign wr_pos   = QPosW'(q_cnt_ff - QCntW'(load));
   assign q_cnt_in = q_cnt_ff + QCntW'(frame_valid) - QCntW'(load);

   // queue of converted items; head always at slot zero
   always_ff @(posedge clock) begin
      if (frame_valid && (wr_pos == QPosW'(0))) begin
         q_ff[0] <= frame_data;
      end else if (load) begin
         q_ff[0] <= q_ff[1];
      end
      if (frame_valid && (wr_pos == QPosW'(1))) begin
         q_ff[1] <= frame_data;
      end
   end

   // character for the current position
   always_comb begin
      sym_pos = idx_ff - IDX_W'(PREFIX_LEN);
      sym_sel = SEL_W'(SYMBOL_COUNT - 1) - SEL_W'(sym_pos);
      id_pos  = idx_ff - IDX_W'(PREFIX_LEN + SYMBOL_COUNT);
      id_sel  = 2'(ID_LEN - 1) - id_pos[1:0];
      case (idx_ff) inside
         [0 : PREFIX_LEN - 1]: begin
            ch = PREFIX_TEXT[idx_ff[2:0]];
         end
         [PREFIX_LEN : PREFIX_LEN + SYMBOL_COUNT - 1]: begin
            ch = symbol_of(cur_ff.digits[sym_sel]);
         end
         default: begin
            ch = cur_ff.use_code ? cfg.setup_id_chars[id_sel] : ASCII_ZERO;
         end
      endcase
   end

   always_comb begin
      cur_in       = cur_ff;
      cur_valid_in = cur_valid_ff;
      idx_in       = idx_ff;
      if (load) begin
         cur_in       = q_ff[0];
         cur_valid_in = 1'b1;
         idx_in       = '0;
      end else if (cur_done) begin
         cur_valid_in = 1'b0;
      end else if (emit) begin
         idx_in = idx_ff + IDX_W'(1);
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (emit) begin
         rsp_valid_in  = 1'b1;
         rsp_in.symbol = ch;
         rsp_in.last   = (idx_ff == IDX_W'(PAYLOAD_LEN - 1));
      end else if (out_free) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         q_cnt_ff     <= '0;
         cur_valid_ff <= 1'b0;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         q_cnt_ff     <= q_cnt_in;
         cur_valid_ff <= cur_valid_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

>>> hw/rtl/setup_payload_base36_encoder_core.sv
// Setup payload encoder, base-36 text form.
// req channel: one item carries eight setup-code digits, paired and has_code.
// rsp channel: twenty ASCII characters per item, last set on the twentieth.
// csr channel: register writes (category, BLE, IP, setup ID); always ready.
// The user must write them only while no item is in flight; the block does
// not enforce it. Unknown indexes are dropped. The packed 48-bit word is
// shifted into a row of nine base-36 cells, three bits a cycle; the carry
// walks one cell per cycle. An item's first character passes the pair sums,
// feed, cells, queue and output register, later while earlier items are sent.
// Throughput: one character per cycle while rsp_ready is high, set by the
// output port; conversion of the next item overlaps the current output.
// Up to three items may be in flight; req_ready drops when that is reached
// or when stage one holds an item the busy feed stage cannot yet take.
// A stalled receiver holds the output register; conversion finishes and
// is parked in a two-entry queue, and new items wait on req_ready.
// Reset clears all control state and loads the register defaults
// (category 1, BLE and IP on, setup ID "0000").
module setup_payload_base36_encoder_core
   import sp36_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  req_type                req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output rsp_type                rsp_data,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [31:0]            csr_data
);

   cfg_type                cfg_ff, cfg_in;
   logic [INFLIGHT_W-1:0]  inflight_ff, inflight_in;
   logic                   slot_free;
   logic                   req_take, rsp_done;
   step_type               chain [SYMBOL_COUNT + 1];
   frame_type              frame;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_CATEGORY: cfg_in.category       = csr_data[7:0];
            CSR_BLE:      cfg_in.ble_supported  = csr_data[0];
            CSR_IP:       cfg_in.ip_supported   = csr_data[0];
            CSR_SETUP_ID: cfg_in.setup_id_chars = csr_data;
            default: ;
         endcase
      end
   end

   assign req_ready = slot_free && (inflight_ff != INFLIGHT_W'(MAX_INFLIGHT));
   assign req_take  = req_valid && req_ready;
   assign rsp_done  = rsp_valid && rsp_ready && rsp_data.last;
   assign inflight_in = inflight_ff + INFLIGHT_W'(req_take) - INFLIGHT_W'(rsp_done);

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.category       <= 8'd1;
         cfg_ff.ble_supported  <= 1'b1;
         cfg_ff.ip_supported   <= 1'b1;
         cfg_ff.setup_id_chars <= {ID_LEN{ASCII_ZERO}};
         inflight_ff           <= '0;
      end else begin
         cfg_ff      <= cfg_in;
         inflight_ff <= inflight_in;
      end
   end

   sp36_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .req_take  (req_take),
      .cfg       (cfg_ff),
      .slot_free (slot_free),
      .chain_out (chain[0])
   );

   // cell 0 holds the least significant base-36 digit
   for (genvar k = 0; k < SYMBOL_COUNT; k++) begin : g_cell
      sp36_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .chain_in  (chain[k]),
         .chain_out (chain[k + 1]),
         .result    (frame.digits[k])
      );
   end

   assign frame.use_code = chain[SYMBOL_COUNT].tag;

   sp36_ser u_ser (
      .clock       (clock),
      .reset       (reset),
      .frame_valid (chain[SYMBOL_COUNT].valid && chain[SYMBOL_COUNT].last),
      .frame_data  (frame),
      .cfg         (cfg_ff),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data)
   );

endmodule
